// ----- rtl/icfir_pkg.sv -----
// Shared types, widths and the output rounding function for the
// interpolated-coefficient multichannel FIR core. No dependencies.
package icfir_pkg;

  localparam int NUM_CH  = 8;   // channel fields carried by one tap request
  localparam int LANES   = 8;   // channel lanes built in hardware, 1..8
  localparam int COEF_W  = 18;
  localparam int FRAC_W  = 16;
  localparam int SMP_W   = 16;
  localparam int OUT_W   = 16;
  localparam int PROD_W  = COEF_W + SMP_W;
  localparam int ACC_W   = 48;
  localparam int CNT_W   = 4;

  localparam int IN_BITS  = 2 * COEF_W + FRAC_W + NUM_CH * SMP_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DW   = NUM_CH * OUT_W;
  localparam int SMP_LSB  = 2 * COEF_W + FRAC_W;

  localparam int ADDR_W   = 3;
  localparam logic REG_CHANNEL_COUNT = 1'b0;   // register index decoded from paddr[2]
  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = CNT_W'(1);

  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

  typedef logic signed [ACC_W-1:0] acc_arr_t [LANES];

  // Add one half LSB of Q1.15, floor-shift by 16 and saturate to 16 bits.
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]    t;
    logic signed [ACC_W-16:0] r;
    t = (ACC_W+1)'(a) + (ACC_W+1)'(32768);
    r = t[ACC_W:16];
    if (r > (ACC_W-15)'(32767)) begin
      round_sat = 16'sh7fff;
    end else if (r < -(ACC_W-15)'(32768)) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = r[OUT_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/icfir_coef.sv -----
// Coefficient interpolation stage: coef = a + floor((b - a) * frac / 2^16).
// Depends on icfir_pkg.
module icfir_coef import icfir_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic        [FRAC_W-1:0] frac,
  output logic signed [COEF_W-1:0] coef
);

  logic signed [COEF_W:0]          diff;
  logic signed [COEF_W+FRAC_W+1:0] prod;
  logic signed [COEF_W+1:0]        step;
  logic signed [COEF_W+1:0]        coef_next;

  always_comb begin
    diff      = (COEF_W+1)'(coef_b) - (COEF_W+1)'(coef_a);
    prod      = (COEF_W+FRAC_W+2)'(diff) * (COEF_W+FRAC_W+2)'($signed({1'b0, frac}));
    step      = prod[COEF_W+FRAC_W+1:FRAC_W];
    coef_next = (COEF_W+2)'(coef_a) + step;
  end

  // The interpolated value always lies between a and b, so 18 bits hold it.
  always_ff @(posedge clk) begin
    if (en) begin
      coef <= coef_next[COEF_W-1:0];
    end
  end

endmodule

// ----- rtl/icfir_lane.sv -----
// One channel lane: sample times coefficient, then a 48-bit wrapping
// accumulator that is dumped and cleared on the last tap. Depends on icfir_pkg.
module icfir_lane import icfir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  ctrl_t                    ctrl_c,
  input  ctrl_t                    ctrl_p,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [SMP_W-1:0]  sample,
  output logic signed [ACC_W-1:0]  sum
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;

  assign acc_next = acc + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (en && ctrl_c.valid) begin
      prod <= PROD_W'(sample) * PROD_W'(coef);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (en && ctrl_p.valid) begin
      acc <= ctrl_p.last ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctrl_p.valid && ctrl_p.last) begin
      sum <= acc_next;
    end
  end

endmodule

// ----- rtl/icfir_merge.sv -----
// Merging stage: rounds and saturates each lane's sum, zeroes inactive
// channels and holds the packed result request. Depends on icfir_pkg.
module icfir_merge import icfir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              sum_valid,
  input  logic [CNT_W-1:0]  channel_count,
  input  acc_arr_t          sums,
  output logic              out_valid,
  output logic [OUT_DW-1:0] out_data
);

  logic [OUT_DW-1:0] data_next;

  always_comb begin
    data_next = '0;
    for (int k = 0; k < LANES; k++) begin
      if (CNT_W'(k) < channel_count) begin
        data_next[k*OUT_W +: OUT_W] = round_sat(sums[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && sum_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/interpolated_coef_fir_multichannel_core.sv -----
// Top level of the interpolated-coefficient multichannel FIR core.
// Depends on icfir_pkg, icfir_coef, icfir_lane and icfir_merge.
//
// Each input request is one filter tap: two neighboring coefficient phases,
// an interpolation fraction and one Q1.15 sample per channel. The block
// interpolates the coefficient once, then eight lanes multiply their own
// sample by it and add the product into a 48-bit accumulator, side by side.
// A request with tlast set closes the output sample: after that tap is added,
// every lane's sum is rounded and saturated to Q1.15 and sent as one result
// request, and the accumulators restart from zero. Channels at or above
// channel_count read as zero. The core takes one tap per clock cycle; the
// result of a closing tap is valid once it has passed the coefficient,
// product, sum and output registers. The pipeline moves as a whole, so
// while a result waits on m_tready the core takes no new tap. channel_count
// is written through the register port at byte address 0 and resets to 1;
// it should only change while the core holds no unfinished taps.
module interpolated_coef_fir_multichannel_core import icfir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // Tap requests.
  input  logic              s_tvalid,
  output logic              s_tready,
  // coef_a[17:0], coef_b[35:18], frac[51:36], sample_0..sample_7 in 16-bit
  // slices from bit 52 up, zero fill [183:180]
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              s_tlast,   // last_tap
  // Result requests.
  output logic              m_tvalid,
  input  logic              m_tready,
  // out_0..out_7 in 16-bit slices from bit 0 up
  output logic [OUT_DW-1:0] m_tdata,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CNT_W-1:0] channel_count;
  logic             en;
  ctrl_t            ctrl_c;
  ctrl_t            ctrl_p;
  logic             sum_valid;
  logic signed [COEF_W-1:0] coef;
  logic signed [SMP_W-1:0]  smp_c [LANES];
  acc_arr_t                 sums;

  // The whole pipeline advances unless a finished result is still waiting.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Register port: always ready; paddr[2] selects the register word.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHANNEL_COUNT) ? 32'(channel_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL_COUNT) begin
      channel_count <= pwdata[CNT_W-1:0];
    end
  end

  // Control pipeline shared by all lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_c    <= '0;
      ctrl_p    <= '0;
      sum_valid <= 1'b0;
    end else if (en) begin
      ctrl_c.valid <= s_tvalid;
      ctrl_c.last  <= s_tlast;
      ctrl_p       <= ctrl_c;
      sum_valid    <= ctrl_p.valid && ctrl_p.last;
    end
  end

  // Samples travel beside the interpolated coefficient.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        smp_c[k] <= s_tdata[SMP_LSB + k*SMP_W +: SMP_W];
      end
    end
  end

  icfir_coef u_coef (
    .clk    (clk),
    .en     (en),
    .coef_a (s_tdata[COEF_W-1:0]),
    .coef_b (s_tdata[2*COEF_W-1:COEF_W]),
    .frac   (s_tdata[SMP_LSB-1:2*COEF_W]),
    .coef   (coef)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    icfir_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctrl_c (ctrl_c),
      .ctrl_p (ctrl_p),
      .coef   (coef),
      .sample (smp_c[g]),
      .sum    (sums[g])
    );
  end

  icfir_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .sum_valid     (sum_valid),
    .channel_count (channel_count),
    .sums          (sums),
    .out_valid     (m_tvalid),
    .out_data      (m_tdata)
  );

`ifndef ASSERT_OFF
  // A result only appears when a closing tap reached the sum register.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> $past(sum_valid))
    else $error("result request without a closing tap");

  // A closing tap moves from the coefficient stage into the product stage.
  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    (en && ctrl_c.valid && ctrl_c.last) |=> (ctrl_p.valid && ctrl_p.last))
    else $error("closing tap lost between stages");

  // With no active channel every output field is zero.
  a_zero_channels: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && channel_count == '0) |-> (m_tdata == '0))
    else $error("output nonzero with no active channel");
`endif

endmodule
